// ===== hdl/pulse_shape_classifier_unit_assert.svh =====
// Assertion macros for the pulse shape classifier.
// Included by the modules that check their own logic; no other dependencies.
`ifndef PULSE_SHAPE_CLASSIFIER_UNIT_ASSERT_SVH
`define PULSE_SHAPE_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define PSC_ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("psc assertion failed");

// next-cycle implication
`define PSC_ASSERT_NXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("psc assertion failed");

`endif

// ===== hdl/psc_pkg.sv =====
// Package for the pulse shape classifier: widths, register codes, types.
// No dependencies; used by psc_front, psc_queue, psc_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

	localparam int SAMPLES_DEF = 32;
	localparam int RAW_W       = 10;
	localparam int SMP_W       = 8;
	localparam int TIME_W      = 16;
	localparam int AREA_W      = 22;
	localparam int CFG_W       = 21;
	localparam int CFG_IDX_W   = 3;
	localparam int IDX_MAX_W   = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] AREA_MAX = 32'd4194303;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL  = 3'd0,
		REG_MAX_RAW   = 3'd1,
		REG_MIN_AMP   = 3'd2,
		REG_DECAY_LIM = 3'd3,
		REG_RISE_LIM  = 3'd4,
		REG_AREA_LIM  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  interval;
		logic [9:0]  max_raw;
		logic [7:0]  min_amp;
		logic [15:0] decay_lim;
		logic [15:0] rise_lim;
		logic [20:0] area_lim;
	} cfg_t;

	typedef struct packed {
		logic                 discarded;
		logic [SMP_W-1:0]     peak;
		logic [IDX_MAX_W-1:0] pidx;
		logic                 bank;
	} job_t;

	typedef struct packed {
		logic              discarded;
		logic [SMP_W-1:0]  peak_level;
		logic [TIME_W-1:0] rise_time_us;
		logic              decay_valid;
		logic [TIME_W-1:0] decay_time_us;
		logic [AREA_W-1:0] twice_area;
		logic              neutron_flag;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_MUL,
		BK_FIN
	} back_state_t;

	// floor(v / 10) for 8-bit v: reciprocal multiply, exact over the range
	function automatic logic [SMP_W-1:0] tenth_of(input logic [SMP_W-1:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd205;
		return SMP_W'(p >> 11);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/psc_sample_if.sv =====
// Sample channel: valid/ready handshake carrying one raw converter sample.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface psc_sample_if;
	logic       valid;
	logic       ready;
	logic [9:0] raw_sample;

	modport source(output valid, output raw_sample, input ready);
	modport sink(input valid, input raw_sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/psc_result_if.sv =====
// Result channel: valid/ready handshake carrying one pulse classification.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface psc_result_if;
	logic        valid;
	logic        ready;
	logic        discarded;
	logic [7:0]  peak_level;
	logic [15:0] rise_time_us;
	logic        decay_valid;
	logic [15:0] decay_time_us;
	logic [21:0] twice_area;
	logic        neutron_flag;

	modport source(output valid, output discarded, output peak_level, output rise_time_us,
		output decay_valid, output decay_time_us, output twice_area, output neutron_flag,
		input ready);
	modport sink(input valid, input discarded, input peak_level, input rise_time_us,
		input decay_valid, input decay_time_us, input twice_area, input neutron_flag,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/psc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/psc_front.sv =====
// Front end: takes samples, checks saturation, stores them, tracks the peak,
// and queues one job per pulse. Depends on psc_pkg and psc_sample_if.
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_shape_classifier_unit_assert.svh"

module psc_front #(
	parameter int SAMPLES = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	psc_sample_if.sink                         sample_ch,
	input  wire logic [9:0]                    max_raw,
	output psc_pkg::job_t                      job,
	output logic                               job_push,
	input  wire logic                          job_full,
	input  wire logic                          walk_done,
	output logic                               wr_en,
	output logic [$clog2(SAMPLES):0]           wr_addr,
	output logic [psc_pkg::SMP_W-1:0]          wr_data
);
	import psc_pkg::*;

	localparam int IDX_W = $clog2(SAMPLES);

	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] peak_pos_q;
	logic [SMP_W-1:0] peak_q;
	logic             bank_q;
	logic [1:0]       pend_q;

	logic             acc;
	logic             sat;
	logic             last;
	logic             bigger;
	logic [SMP_W-1:0] s;

	// both banks held by the back end: the current bank is not free
	assign sample_ch.ready = !job_full && (pend_q != 2'd2);
	assign acc    = sample_ch.valid && sample_ch.ready;
	assign sat    = sample_ch.raw_sample >= max_raw;
	assign s      = sample_ch.raw_sample[9:2];
	assign last   = pos_q == IDX_W'(SAMPLES - 1);
	assign bigger = s > peak_q;

	assign wr_en   = acc && !sat;
	assign wr_addr = {bank_q, pos_q};
	assign wr_data = s;

	assign job_push      = acc && (sat || last);
	assign job.discarded = sat;
	assign job.peak      = bigger ? s : peak_q;
	assign job.pidx      = IDX_MAX_W'(bigger ? pos_q : peak_pos_q);
	assign job.bank      = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			peak_pos_q <= '0;
			peak_q     <= '0;
			bank_q     <= 1'b0;
			pend_q     <= '0;
		end else begin
			if (acc) begin
				if (sat || last) begin
					pos_q      <= '0;
					peak_pos_q <= '0;
					peak_q     <= '0;
					if (!sat) begin
						bank_q <= !bank_q;
					end
				end else begin
					pos_q <= pos_q + 1'b1;
					if (bigger) begin
						peak_q     <= s;
						peak_pos_q <= pos_q;
					end
				end
			end
			pend_q <= pend_q + 2'(job_push && !sat) - 2'(walk_done);
		end
	end

	`PSC_ASSERT_IMP(a_pend_range, clk, arst_n, 1'b1, pend_q != 2'd3)
	`PSC_ASSERT_IMP(a_no_overwrite, clk, arst_n, wr_en, pend_q != 2'd2)
	`PSC_ASSERT_NXT(a_bank_flip, clk, arst_n, job_push && !sat, bank_q != $past(bank_q))
	`PSC_ASSERT_NXT(a_restart, clk, arst_n, job_push, pos_q == '0)

endmodule

`default_nettype wire

// ===== hdl/psc_queue.sv =====
// Two-entry job queue between the front and back ends.
// Depends on psc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psc_queue (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire psc_pkg::job_t din,
	output logic         full,
	input  wire logic    pop,
	output logic         empty,
	output psc_pkg::job_t dout
);
	import psc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = cnt_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/psc_back.sv =====
// Back end: walks one stored pulse, finds rise/decay points and area,
// scales by the interval and drives the result register. Depends on psc_pkg, psc_result_if.
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_shape_classifier_unit_assert.svh"

module psc_back #(
	parameter int SAMPLES = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire psc_pkg::cfg_t        cfg,
	input  wire psc_pkg::job_t        job,
	input  wire logic                 job_empty,
	output logic                      job_pop,
	output logic                      rd_en,
	output logic [$clog2(SAMPLES):0]  rd_addr,
	input  wire logic [psc_pkg::SMP_W-1:0] rd_data,
	output logic                      walk_done,
	psc_result_if.source              result_ch
);
	import psc_pkg::*;

	localparam int IDX_W   = $clog2(SAMPLES);
	localparam int PAIR_W  = IDX_W + 9;
	localparam int TPROD_W = IDX_W + 8;
	localparam int APROD_W = PAIR_W + 8;

	back_state_t state_q, state_d;

	logic               disc_q;
	logic [SMP_W-1:0]   peak_q;
	logic [IDX_W-1:0]   pidx_q;
	logic               bank_q;
	logic [SMP_W-1:0]   tenth_q;

	logic [IDX_W-1:0]   iss_q;
	logic               iss_on_q;
	logic               dval_s1;
	logic [IDX_W-1:0]   didx_s1;

	logic               f10_q, f90_q, fdk_q;
	logic [IDX_W-1:0]   t10_q, t90_q, tdk_q;
	logic [PAIR_W-1:0]  pair_q;

	logic [TPROD_W-1:0] rise_p_q;
	logic [TPROD_W-1:0] decay_p_q;
	logic [APROD_W-1:0] area_p_q;
	logic               ok_q;

	logic               res_valid_q;
	result_t            res_q;
	logic               res_load;

	logic [11:0]        s10, p1, p9;
	logic               d_last, d_edge;
	logic [TIME_W-1:0]  rise16, decay16;
	logic [AREA_W-1:0]  area22;
	result_t            res_d;

	assign rd_addr = {bank_q, iss_q};

	assign s10    = 12'(rd_data) * 12'd10;
	assign p1     = 12'(peak_q);
	assign p9     = 12'(peak_q) * 12'd9;
	assign d_last = didx_s1 == IDX_W'(SAMPLES - 1);
	assign d_edge = (didx_s1 == '0) || d_last;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					state_d = job.discarded ? BK_FIN : BK_WALK;
				end
			end
			BK_WALK: begin
				if (dval_s1 && d_last) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_FIN;
			end
			BK_FIN: begin
				if (!res_valid_q || result_ch.ready) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		job_pop   = 1'b0;
		rd_en     = 1'b0;
		walk_done = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				job_pop = !job_empty;
			end
			BK_WALK: begin
				rd_en     = iss_on_q;
				walk_done = dval_s1 && d_last;
			end
			BK_MUL: begin
			end
			BK_FIN: begin
				res_load = !res_valid_q || result_ch.ready;
			end
			default: begin
			end
		endcase
	end

	// result assembly
	assign rise16  = TIME_W'(rise_p_q);
	assign decay16 = TIME_W'(decay_p_q);
	assign area22  = (32'(area_p_q) > AREA_MAX) ? AREA_W'(AREA_MAX) : AREA_W'(area_p_q);

	always_comb begin
		res_d = '0;
		res_d.discarded = disc_q;
		if (!disc_q) begin
			res_d.peak_level    = peak_q;
			res_d.rise_time_us  = rise16;
			res_d.decay_valid   = ok_q;
			res_d.decay_time_us = ok_q ? decay16 : '0;
			res_d.twice_area    = area22;
			res_d.neutron_flag  = ok_q && (decay16 > cfg.decay_lim)
				&& (rise16 > cfg.rise_lim) && (area22 > {cfg.area_lim, 1'b0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			iss_q       <= '0;
			iss_on_q    <= 1'b0;
			dval_s1     <= 1'b0;
			f10_q       <= 1'b0;
			f90_q       <= 1'b0;
			fdk_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dval_s1 <= rd_en;
			if (job_pop) begin
				iss_q    <= '0;
				iss_on_q <= !job.discarded;
				f10_q    <= 1'b0;
				f90_q    <= 1'b0;
				fdk_q    <= 1'b0;
			end else if (rd_en) begin
				iss_q <= iss_q + 1'b1;
				if (iss_q == IDX_W'(SAMPLES - 1)) begin
					iss_on_q <= 1'b0;
				end
			end
			if (dval_s1) begin
				if (s10 >= p1) begin
					f10_q <= 1'b1;
				end
				if (s10 >= p9) begin
					f90_q <= 1'b1;
				end
				if ((didx_s1 >= pidx_q) && (rd_data < tenth_q)) begin
					fdk_q <= 1'b1;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		didx_s1 <= iss_q;
		if (job_pop) begin
			disc_q  <= job.discarded;
			peak_q  <= job.peak;
			pidx_q  <= IDX_W'(job.pidx);
			bank_q  <= job.bank;
			tenth_q <= tenth_of(job.peak);
			t10_q   <= '0;
			t90_q   <= '0;
			tdk_q   <= '0;
			pair_q  <= '0;
		end
		if (dval_s1) begin
			if (!f10_q && (s10 >= p1)) begin
				t10_q <= didx_s1;
			end
			if (!f90_q && (s10 >= p9)) begin
				t90_q <= didx_s1;
			end
			if (!fdk_q && (didx_s1 >= pidx_q) && (rd_data < tenth_q)) begin
				tdk_q <= didx_s1 - pidx_q;
			end
			pair_q <= pair_q + (d_edge ? PAIR_W'(rd_data) : PAIR_W'({rd_data, 1'b0}));
		end
		if (state_q == BK_MUL) begin
			rise_p_q  <= TPROD_W'(t90_q - t10_q) * TPROD_W'(cfg.interval);
			decay_p_q <= TPROD_W'(tdk_q) * TPROD_W'(cfg.interval);
			area_p_q  <= APROD_W'(pair_q) * APROD_W'(cfg.interval);
			ok_q      <= fdk_q && (peak_q >= cfg.min_amp);
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign result_ch.valid         = res_valid_q;
	assign result_ch.discarded     = res_q.discarded;
	assign result_ch.peak_level    = res_q.peak_level;
	assign result_ch.rise_time_us  = res_q.rise_time_us;
	assign result_ch.decay_valid   = res_q.decay_valid;
	assign result_ch.decay_time_us = res_q.decay_time_us;
	assign result_ch.twice_area    = res_q.twice_area;
	assign result_ch.neutron_flag  = res_q.neutron_flag;

	`PSC_ASSERT_NXT(a_t90_found, clk, arst_n, walk_done, f90_q && f10_q)
	`PSC_ASSERT_IMP(a_rise_order, clk, arst_n, f90_q, f10_q && (t10_q <= t90_q))
	`PSC_ASSERT_IMP(a_data_in_walk, clk, arst_n, dval_s1, state_q == BK_WALK)

endmodule

`default_nettype wire

// ===== hdl/pulse_shape_classifier_unit.sv =====
// Pulse shape classifier: one sample accepted per cycle unless the input stalls (job
// queue full or both banks held), one result per pulse. The back end walks the stored
// pulse through one RAM read port.
// Samples are buffered in two banks, so a new pulse fills while the last is walked.
// A saturated sample ends its pulse and gives a discarded result without a walk.
// Reset: registers to defaults, pulse tracking and queue cleared; buffer not cleared.
`timescale 1ns / 1ps
`default_nettype none

module pulse_shape_classifier_unit #(
	parameter int SAMPLES = psc_pkg::SAMPLES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [psc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [psc_pkg::CFG_W-1:0]      cfg_data,
	psc_sample_if.sink                          sample_ch,
	psc_result_if.source                        result_ch
);
	import psc_pkg::*;

	localparam int IDX_W = $clog2(SAMPLES);
	localparam int DEPTH = 2 * (1 << IDX_W);

	cfg_t             cfg_q;
	job_t             job_in, job_out;
	logic             job_push, job_pop, job_full, job_empty;
	logic             walk_done;
	logic             wr_en, rd_en;
	logic [IDX_W:0]   wr_addr, rd_addr;
	logic [SMP_W-1:0] wr_data, rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval  <= 8'd1;
			cfg_q.max_raw   <= 10'd1023;
			cfg_q.min_amp   <= '0;
			cfg_q.decay_lim <= '0;
			cfg_q.rise_lim  <= '0;
			cfg_q.area_lim  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_INTERVAL:  cfg_q.interval  <= cfg_data[7:0];
				REG_MAX_RAW:   cfg_q.max_raw   <= cfg_data[9:0];
				REG_MIN_AMP:   cfg_q.min_amp   <= cfg_data[7:0];
				REG_DECAY_LIM: cfg_q.decay_lim <= cfg_data[15:0];
				REG_RISE_LIM:  cfg_q.rise_lim  <= cfg_data[15:0];
				REG_AREA_LIM:  cfg_q.area_lim  <= cfg_data[20:0];
				default: begin
				end
			endcase
		end
	end

	psc_front #(.SAMPLES(SAMPLES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.max_raw   (cfg_q.max_raw),
		.job       (job_in),
		.job_push  (job_push),
		.job_full  (job_full),
		.walk_done (walk_done),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	psc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.empty  (job_empty),
		.dout   (job_out)
	);

	psc_ram #(.WIDTH(SMP_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	psc_back #(.SAMPLES(SAMPLES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.walk_done (walk_done),
		.result_ch (result_ch)
	);

endmodule

`default_nettype wire
